### sv/matrix_vector_transform_4x4_core_defines.svh
// Assertion macros for the 4x4 matrix-vector transform core.
// Used by the port checker; depends on nothing else.
`ifndef MATRIX_VECTOR_TRANSFORM_4X4_CORE_DEFINES_SVH
`define MATRIX_VECTOR_TRANSFORM_4X4_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MVT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("mvt: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MVT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("mvt: assertion failed");

`endif

### sv/mvt_pkg.sv
// Shared types and constants of the 4x4 matrix-vector transform core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mvt_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned DIM_MAX = 4;
  localparam int unsigned IDX_W   = 2;
  localparam int unsigned PROD_W  = 2 * DATA_W;
  localparam int unsigned PAIR_W  = PROD_W + 1;
  localparam int unsigned SUM_W   = PROD_W + 2;

  // Input tdata layout, lowest bit first: row, col, coef, x0..x3.
  localparam int unsigned ROW_LSB   = 0;
  localparam int unsigned COL_LSB   = ROW_LSB + IDX_W;
  localparam int unsigned COEF_LSB  = COL_LSB + IDX_W;
  localparam int unsigned X_LSB     = COEF_LSB + DATA_W;
  localparam int unsigned S_FIELD_W = X_LSB + DIM_MAX * DATA_W;
  localparam int unsigned S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = DIM_MAX * DATA_W;

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_e;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef word_t [DIM_MAX-1:0]      vec_t;
  typedef vec_t  [DIM_MAX-1:0]      mat_t;

  // One coefficient write into the stored matrix.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    word_t            data;
  } coef_wr_t;

  // Load enables of the four pipeline register stages.
  typedef struct packed {
    logic prod;
    logic pair;
    logic sum;
    logic out;
  } stage_en_t;

endpackage

### sv/mvt_coef_store.sv
// Coefficient matrix storage of the transform core, cleared at reset.
// Depends on mvt_pkg.
`timescale 1ns / 1ps

module mvt_coef_store
  import mvt_pkg::*;
#(
  parameter int unsigned DIM = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  coef_wr_t wr_i,
  output mat_t     mat_o
);

  // Only the DIM x DIM corner exists; the rest of the matrix reads as zero.
  for (genvar r = 0; r < DIM_MAX; r++) begin : g_row
    for (genvar c = 0; c < DIM_MAX; c++) begin : g_col
      if (r < DIM && c < DIM) begin : g_reg
        word_t coef_q;
        logic  hit;

        assign hit = wr_i.we && (wr_i.row == IDX_W'(r)) && (wr_i.col == IDX_W'(c));

        always_ff @(posedge clk_i or negedge rst_ni) begin
          if (!rst_ni) begin
            coef_q <= '0;
          end else if (hit) begin
            coef_q <= wr_i.data;
          end
        end

        assign mat_o[r][c] = coef_q;
      end else begin : g_zero
        assign mat_o[r][c] = '0;
      end
    end
  end

endmodule

### sv/mvt_row_dot.sv
// One row lane of the transform core: multiply, pair add, final add,
// then floor shift and saturation. Depends on mvt_pkg.
`timescale 1ns / 1ps

module mvt_row_dot
  import mvt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  stage_en_t en_i,
  input  vec_t      coefs_i,
  input  vec_t      x_i,
  output word_t     y_o,
  output logic      ovf_o
);

  logic signed [PROD_W-1:0] prod_d [DIM_MAX];
  logic signed [PROD_W-1:0] prod_q [DIM_MAX];
  logic signed [PAIR_W-1:0] pair_d [2];
  logic signed [PAIR_W-1:0] pair_q [2];
  logic signed [SUM_W-1:0]  sum_d;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SUM_W-1:0]  shifted;
  logic [SUM_W-DATA_W:0]    upper;
  logic                     fits;
  word_t                    y_d;
  word_t                    y_q;
  logic                     ovf_d;
  logic                     ovf_q;

  always_comb begin
    for (int c = 0; c < DIM_MAX; c++) begin
      prod_d[c] = PROD_W'(coefs_i[c]) * PROD_W'(x_i[c]);
    end
  end

  assign pair_d[0] = PAIR_W'(prod_q[0]) + PAIR_W'(prod_q[1]);
  assign pair_d[1] = PAIR_W'(prod_q[2]) + PAIR_W'(prod_q[3]);
  assign sum_d     = SUM_W'(pair_q[0]) + SUM_W'(pair_q[1]);

  // The arithmetic shift rounds toward minus infinity; the result fits when
  // every bit from the 32-bit sign bit upward agrees.
  assign shifted = sum_q >>> FRAC_BITS;
  assign upper   = shifted[SUM_W-1:DATA_W-1];
  assign fits    = (&upper) || !(|upper);
  assign ovf_d   = !fits;

  always_comb begin
    priority if (fits) begin
      y_d = shifted[DATA_W-1:0];
    end else if (shifted[SUM_W-1]) begin
      y_d = SAT_MIN;
    end else begin
      y_d = SAT_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      prod_q <= prod_d;
    end
    if (en_i.pair) begin
      pair_q <= pair_d;
    end
    if (en_i.sum) begin
      sum_q <= sum_d;
    end
    if (en_i.out) begin
      y_q   <= y_d;
      ovf_q <= ovf_d;
    end
  end

  assign y_o   = y_q;
  assign ovf_o = ovf_q;

endmodule

### sv/matrix_vector_transform_4x4_core.sv
// Top level of the 4x4 matrix-vector transform core.
// Depends on mvt_pkg, mvt_coef_store and mvt_row_dot.
//
// Usage: items arrive on the s_axis channel. tuser carries the operation.
// A load transaction (op 0) writes one signed Q16.16 coefficient at (row, col)
// of the stored matrix and produces no result; a write outside the DIM x DIM
// corner is dropped. A transform transaction (op 1) carries a vector x0..x3 and
// produces one m_axis transaction with the four row dot products, each floor
// shifted by FRAC_BITS and saturated to 32 bits; tuser flags any saturation.
// Rows at or beyond DIM give zero.
// Throughput is one transaction per cycle while m_axis is not stalled, loads and transforms mixed freely.
// A load takes effect for the very next transform transaction.
// From acceptance to the result on m_axis a transform passes one stage of
// sixteen 32x32 multipliers, one stage of pair sums, one final sum stage and
// the shift and saturation stage that is also the output register.
// Each stage has its own valid bit, so a stalled receiver first lets bubbles
// close up before s_axis_tready falls; nothing is lost or repeated.
// Reset clears the matrix to zero and empties the pipeline at once.
`timescale 1ns / 1ps

module matrix_vector_transform_4x4_core
  import mvt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DIM       = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // row[1:0], col[3:2], coef[35:4], x0[67:36], x1[99:68], x2[131:100],
  // x3[163:132], zero fill up to bit 167
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // op[0]
  input  logic [0:0]           s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // y0[31:0], y1[63:32], y2[95:64], y3[127:96]
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  // overflow[0]
  output logic [0:0]           m_axis_tuser_o
);

  localparam int unsigned NUM_STAGES = 4;

  logic                  accept;
  logic                  is_xform;
  logic [NUM_STAGES-1:0] valid_d;
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] stage_rdy;
  stage_en_t             stage_en;
  coef_wr_t              coef_wr;
  mat_t                  mat;
  vec_t                  x_vec;
  logic [DIM_MAX-1:0]    row_ovf;

  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign is_xform = (s_axis_tuser_i == OP_XFORM);

  // A stage can take new data when it is empty or its content moves on.
  always_comb begin
    stage_rdy[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || m_axis_tready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      stage_rdy[k] = !valid_q[k] || stage_rdy[k+1];
    end
  end

  assign s_axis_tready_o = stage_rdy[0];

  always_comb begin
    valid_d[0] = stage_rdy[0] ? (accept && is_xform) : valid_q[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_d[k] = stage_rdy[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign stage_en.prod = accept && is_xform;
  assign stage_en.pair = stage_rdy[1] && valid_q[0];
  assign stage_en.sum  = stage_rdy[2] && valid_q[1];
  assign stage_en.out  = stage_rdy[3] && valid_q[2];

  // Loads write the matrix at acceptance, ahead of any later transform.
  assign coef_wr.we   = accept && !is_xform;
  assign coef_wr.row  = s_axis_tdata_i[ROW_LSB +: IDX_W];
  assign coef_wr.col  = s_axis_tdata_i[COL_LSB +: IDX_W];
  assign coef_wr.data = s_axis_tdata_i[COEF_LSB +: DATA_W];

  mvt_coef_store #(
    .DIM (DIM)
  ) u_coef_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (coef_wr),
    .mat_o  (mat)
  );

  // Vector elements beyond DIM meet zero coefficients and drop out.
  always_comb begin
    for (int c = 0; c < DIM_MAX; c++) begin
      x_vec[c] = s_axis_tdata_i[X_LSB + c * DATA_W +: DATA_W];
    end
  end

  for (genvar r = 0; r < DIM_MAX; r++) begin : g_lane
    if (r < DIM) begin : g_dot
      word_t y;

      mvt_row_dot #(
        .FRAC_BITS (FRAC_BITS)
      ) u_row_dot (
        .clk_i   (clk_i),
        .en_i    (stage_en),
        .coefs_i (mat[r]),
        .x_i     (x_vec),
        .y_o     (y),
        .ovf_o   (row_ovf[r])
      );

      assign m_axis_tdata_o[r * DATA_W +: DATA_W] = y;
    end else begin : g_none
      assign m_axis_tdata_o[r * DATA_W +: DATA_W] = '0;
      assign row_ovf[r] = 1'b0;
    end
  end

  assign m_axis_tvalid_o   = valid_q[NUM_STAGES-1];
  assign m_axis_tuser_o[0] = |row_ovf;

endmodule

### sv/mvt_checker.sv
// Port-level checker of the transform core, bound to the top level.
// Depends on mvt_pkg and matrix_vector_transform_4x4_core_defines.svh.
`timescale 1ns / 1ps
`include "matrix_vector_transform_4x4_core_defines.svh"

module mvt_assertions
  import mvt_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready_o,
  input logic                 m_axis_tvalid_o,
  input logic                 m_axis_tready_i,
  input logic [M_TDATA_W-1:0] m_axis_tdata_o,
  input logic [0:0]           m_axis_tuser_o
);

  logic out_stall;
  logic any_sat;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;

  always_comb begin
    any_sat = 1'b0;
    for (int r = 0; r < DIM_MAX; r++) begin
      any_sat = any_sat || (m_axis_tdata_o[r * DATA_W +: DATA_W] == SAT_MAX)
                        || (m_axis_tdata_o[r * DATA_W +: DATA_W] == SAT_MIN);
    end
  end

  `MVT_ASSERT_NEXT(a_stall_holds_valid, clk_i, rst_ni, out_stall, m_axis_tvalid_o)
  `MVT_ASSERT_NEXT(a_stall_holds_data, clk_i, rst_ni, out_stall, $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
  `MVT_ASSERT_IMPL(a_ovf_means_sat, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[0], any_sat)
  `MVT_ASSERT_IMPL(a_empty_out_ready, clk_i, rst_ni, !m_axis_tvalid_o, s_axis_tready_o)

endmodule

bind matrix_vector_transform_4x4_core mvt_assertions u_mvt_checker (.*);

### tb/mvt_checker.sv
// Checker for the 4x4 matrix-vector transform core: watches both streams,
// predicts every result from its own copy of the matrix and compares.
// Depends on mvt_pkg only.
`timescale 1ns / 1ps

module mvt_checker
  import mvt_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DIM       = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  input  logic                 s_axis_tready_i,
  // row[1:0], col[3:2], coef[35:4], x0..x3[163:36], zero fill up to bit 167
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // op[0]
  input  logic [0:0]           s_axis_tuser_i,
  input  logic                 m_axis_tvalid_i,
  input  logic                 m_axis_tready_i,
  // y0[31:0], y1[63:32], y2[95:64], y3[127:96]
  input  logic [M_TDATA_W-1:0] m_axis_tdata_i,
  // overflow[0]
  input  logic [0:0]           m_axis_tuser_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic ovf;
    vec_t y;
  } xform_out_t;

  word_t       coef_store [DIM_MAX][DIM_MAX];
  xform_out_t  due_results_q [$];
  int unsigned fail_count = 0;

  // Exact row sums, floor shift, then clamp to the 32-bit range.
  function automatic xform_out_t transform_vector(input vec_t x);
    xform_out_t              res;
    logic signed [SUM_W-1:0] acc;
    res = '0;
    for (int r = 0; r < DIM_MAX; r++) begin
      if (r < DIM) begin
        acc = '0;
        for (int c = 0; c < DIM; c++) begin
          acc = acc + $signed(coef_store[r][c]) * $signed(x[c]);
        end
        acc = acc >>> FRAC_BITS;
        if (acc > SAT_MAX) begin
          res.y[r] = SAT_MAX;
          res.ovf  = 1'b1;
        end else if (acc < SAT_MIN) begin
          res.y[r] = SAT_MIN;
          res.ovf  = 1'b1;
        end else begin
          res.y[r] = acc[DATA_W-1:0];
        end
      end
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
    fail_count++;
    $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    xform_out_t       want;
    logic [IDX_W-1:0] wr_row;
    logic [IDX_W-1:0] wr_col;
    if (!rst_ni) begin
      for (int r = 0; r < DIM_MAX; r++) begin
        for (int c = 0; c < DIM_MAX; c++) begin
          coef_store[r][c] = '0;
        end
      end
      due_results_q.delete();
    end else begin
      // Results leave only after their transaction has passed the pipeline registers,
      // so checking the output before taking the input is safe.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (due_results_q.size() == 0) begin
          flag_mismatch("result with nothing due", m_axis_tdata_i[DATA_W-1:0], '0);
        end else begin
          want = due_results_q.pop_front();
          for (int r = 0; r < DIM_MAX; r++) begin
            if (m_axis_tdata_i[r*DATA_W +: DATA_W] !== want.y[r]) begin
              flag_mismatch($sformatf("y%0d", r), m_axis_tdata_i[r*DATA_W +: DATA_W],
                            want.y[r]);
            end
          end
          if (m_axis_tuser_i[0] !== want.ovf) begin
            flag_mismatch("overflow", DATA_W'(m_axis_tuser_i[0]), DATA_W'(want.ovf));
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (s_axis_tuser_i == OP_LOAD) begin
          wr_row = s_axis_tdata_i[ROW_LSB +: IDX_W];
          wr_col = s_axis_tdata_i[COL_LSB +: IDX_W];
          if (wr_row < DIM && wr_col < DIM) begin
            coef_store[wr_row][wr_col] = s_axis_tdata_i[COEF_LSB +: DATA_W];
          end
        end else begin
          due_results_q.push_back(
              transform_vector(s_axis_tdata_i[X_LSB +: DIM_MAX*DATA_W]));
        end
      end
    end
    pending_o    <= due_results_q.size();
    fail_count_o <= fail_count;
  end

endmodule

### tb/tb_matrix_vector_transform_4x4_core.sv
// Testbench top for the 4x4 matrix-vector transform core: drives directed and
// random load and transform transactions with random idling on both streams.
// Depends on mvt_pkg, the core and mvt_checker.
`timescale 1ns / 1ps

module tb_matrix_vector_transform_4x4_core;
  import mvt_pkg::*;

  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned DIM          = 4;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int unsigned HOLD_AT      = 300;   // item at which the long hold-off starts
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned QUIET_FROM   = 1000;  // no idling from this item on
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned LIMIT_CYCLES = 200000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [0:0]           s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]           m_axis_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_cnt = 0;
  bit          idle_on   = 1'b1;  // sender inserts gaps
  bit          rx_quiet  = 1'b0;  // receiver stops stalling
  bit          hold_go   = 1'b0;  // request for one long receiver hold-off

  always #4 clk = ~clk;

  matrix_vector_transform_4x4_core #(
    .FRAC_BITS(FRAC_BITS),
    .DIM      (DIM)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  mvt_checker #(
    .FRAC_BITS(FRAC_BITS),
    .DIM      (DIM)
  ) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .m_axis_tuser_i (m_axis_tuser),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Mostly small Q16.16 values so that sums stay in range, with full-range
  // words and the corner values mixed in to drive saturation.
  function automatic word_t rand_word();
    logic [DATA_W-1:0] w;
    case ($urandom_range(0, 5))
      0: w = $urandom;
      1: begin
        case ($urandom_range(0, 5))
          0:       w = SAT_MAX;
          1:       w = SAT_MIN;
          2:       w = '0;
          3:       w = '1;
          4:       w = 32'h0001_0000;
          default: w = 32'hFFFF_0000;
        endcase
      end
      default: w = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
    return w;
  endfunction

  function automatic logic [S_TDATA_W-1:0] pack_item(input logic [IDX_W-1:0] row,
                                                     input logic [IDX_W-1:0] col,
                                                     input word_t coef, input vec_t x);
    logic [S_TDATA_W-1:0] d;
    d                           = '0;
    d[ROW_LSB +: IDX_W]         = row;
    d[COL_LSB +: IDX_W]         = col;
    d[COEF_LSB +: DATA_W]       = coef;
    d[X_LSB +: DIM_MAX*DATA_W]  = x;
    return d;
  endfunction

  // Offers one transaction and waits for it to be taken. tvalid is only
  // dropped for a gap, so back-to-back transactions keep it high.
  task automatic put_item(input op_e op, input logic [S_TDATA_W-1:0] data);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // The vector fields of a load are random junk that must be ignored.
  task automatic load_coef(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                           input word_t coef);
    put_item(OP_LOAD, pack_item(row, col, coef, {$urandom, $urandom, $urandom, $urandom}));
  endtask

  // Likewise row, col and coef of a transform are junk.
  task automatic send_vector(input vec_t x);
    put_item(OP_XFORM, pack_item(IDX_W'($urandom), IDX_W'($urandom), $urandom, x));
  endtask

  // Receiver: random ready and stall bursts, one long hold-off on request,
  // and always ready once the quiet part begins.
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_go && !rx_quiet) begin
        hold_go = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_quiet || $urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("tb_matrix_vector_transform_4x4_core failed");
      $finish;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_LOAD;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The matrix starts cleared, so extremes give zero.
    send_vector({SAT_MIN, SAT_MAX, SAT_MIN, SAT_MAX});
    // Identity matrix passes even the extreme elements through unchanged.
    for (int r = 0; r < DIM_MAX; r++) begin
      load_coef(IDX_W'(r), IDX_W'(r), 32'h0001_0000);
    end
    send_vector({32'h0000_0001, 32'hFFFF_FFFF, SAT_MIN, SAT_MAX});
    // Row 0 all maximum, row 3 all minimum: both saturation directions.
    for (int c = 0; c < DIM_MAX; c++) begin
      load_coef(2'd0, IDX_W'(c), SAT_MAX);
      load_coef(2'd3, IDX_W'(c), SAT_MIN);
    end
    send_vector({SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX});
    send_vector({SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN});
    // A tiny coefficient shows the floor shift: -1 * 1 rounds to -1, not 0.
    load_coef(2'd2, 2'd2, 32'h0000_0001);
    send_vector({32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0});
    send_vector({32'h0, 32'h0000_0001, 32'h0, 32'h0});
    send_vector({32'h0, 32'h0, 32'h0, 32'h0});

    // Random part; a long receiver hold-off fills the pipeline midway.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT) begin
        hold_go = 1'b1;
      end
      if (i == QUIET_FROM) begin
        idle_on  = 1'b0;
        rx_quiet = 1'b1;
      end
      if ($urandom_range(0, 9) < 3) begin
        load_coef(IDX_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 3)), rand_word());
      end else begin
        send_vector({rand_word(), rand_word(), rand_word(), rand_word()});
      end
    end
    s_axis_tvalid <= 1'b0;

    // Let the checker see the last transaction before trusting its count.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_matrix_vector_transform_4x4_core passed");
    end else begin
      $display("tb_matrix_vector_transform_4x4_core failed");
    end
    $finish;
  end

endmodule
